// ===== hdl/dpsc_pkg.sv =====
// Shared types, constants and the count saturation function for the
// dual-active-bridge phase-shift compare block. No dependencies.
package dpsc_pkg;

    // Command codes of an input item.
    localparam logic [1:0] CMD_SET_PHASES = 2'd0;
    localparam logic [1:0] CMD_SET_DUTIES = 2'd1;
    localparam logic [1:0] CMD_UPDATE     = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] REG_MASTER_PERIOD    = 2'd0;
    localparam logic [1:0] REG_PRIMARY_PERIOD   = 2'd1;
    localparam logic [1:0] REG_SECONDARY_PERIOD = 2'd2;

    // Reset value of every period register.
    localparam logic [15:0] PERIOD_RESET = 16'hFFFF;

    // Clamp limits: +-0.25 and +-0.4 in Q15, 1.0 in Q16.
    localparam logic signed [15:0] MAIN_LIMIT   = 16'sd8192;
    localparam logic signed [15:0] BRIDGE_LIMIT = 16'sd13107;
    localparam logic [16:0]        DUTY_ONE     = 17'h10000;

    // The four master compare counts of one phase setting.
    typedef struct packed {
        logic [15:0] cmp_a;
        logic [15:0] cmp_pri;
        logic [15:0] cmp_b;
        logic [15:0] cmp_sec;
    } t_phase_counts;

    // Saturate a signed count to the range 1..period-1 (period-1 wraps mod 2^16).
    // The upper bound wins when both bounds apply.
    function automatic logic [15:0] sat_count(input logic signed [18:0] value,
                                              input logic [15:0] period);
        logic [15:0] top;
        begin
            top = period - 16'd1;
            if (value >= $signed({3'b000, top})) begin
                return top;
            end else if (value <= 19'sd1) begin
                return 16'd1;
            end else begin
                return value[15:0];
            end
        end
    endfunction

endpackage

// ===== hdl/dab_phase_shift_setpoint_to_compare.sv =====
// Top level of the dual-active-bridge setpoint to compare converter.
// Depends on dpsc_pkg, dpsc_phase and dpsc_duty.
//
// Usage:
// An input item carries a command and the phase and duty setpoints. Set
// phases writes four master compare counts to the shadow set, set duties
// writes the two duty counts to the shadow set, and update copies the whole
// shadow set to the active set. Every item returns one result item: the
// active set as it stands after that command.
// Channels use valid and stall; an item moves at a clock edge with valid
// high and stall low. An item goes through an input register and then an
// output register. One item is accepted every cycle while the receiver
// takes results; the clamping, multiplies and saturation sit between these
// two registers. When the receiver stalls, the output register holds its
// result and the input register can still take one more item; the input
// stall rises only when both are full.
// The user must write the period registers on the configuration port only
// while no item is in flight; the block itself does not enforce this.
// Synchronous reset empties the pipeline, sets every period to 65535 and
// clears the shadow and active sets to zero.
module dab_phase_shift_setpoint_to_compare
    import dpsc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Configuration write port
    input  logic               i_cfg_wr_en,
    input  logic [1:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data,
    // Input channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_command,
    input  logic signed [15:0] i_main_phase,
    input  logic signed [15:0] i_primary_phase,
    input  logic signed [15:0] i_secondary_phase,
    input  logic [16:0]        i_primary_duty,
    input  logic [16:0]        i_secondary_duty,
    // Output channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [15:0]        o_active_compare_a,
    output logic [15:0]        o_active_compare_pri,
    output logic [15:0]        o_active_compare_b,
    output logic [15:0]        o_active_compare_sec,
    output logic [15:0]        o_active_duty_pri,
    output logic [15:0]        o_active_duty_sec
);

    logic [15:0]        r_master_period;
    logic [15:0]        r_primary_period;
    logic [15:0]        r_secondary_period;

    logic               r_s1_valid;
    logic [1:0]         r_s1_cmd;
    logic signed [15:0] r_s1_main;
    logic signed [15:0] r_s1_pri;
    logic signed [15:0] r_s1_sec;
    logic [16:0]        r_s1_duty_pri;
    logic [16:0]        r_s1_duty_sec;

    t_phase_counts      r_shadow_phase;
    logic [15:0]        r_shadow_duty_pri;
    logic [15:0]        r_shadow_duty_sec;
    t_phase_counts      r_active_phase;
    logic [15:0]        r_active_duty_pri;
    logic [15:0]        r_active_duty_sec;

    logic               r_out_valid;
    t_phase_counts      r_out_phase;
    logic [15:0]        r_out_duty_pri;
    logic [15:0]        r_out_duty_sec;

    t_phase_counts      new_phase;
    logic [15:0]        new_duty_pri;
    logic [15:0]        new_duty_sec;
    t_phase_counts      n_active_phase;
    logic [15:0]        n_active_duty_pri;
    logic [15:0]        n_active_duty_sec;

    logic               in_accept;
    logic               out_free;
    logic               s1_adv;

    // Handshake: the output register frees when empty or taken this cycle.
    assign out_free   = !r_out_valid || !i_out_stall;
    assign s1_adv     = r_s1_valid && out_free;
    assign o_in_stall = r_s1_valid && !out_free;
    assign in_accept  = i_in_valid && !o_in_stall;

    // Count computation from the input register.
    dpsc_phase u_phase (
        .i_master_period   (r_master_period),
        .i_main_phase      (r_s1_main),
        .i_primary_phase   (r_s1_pri),
        .i_secondary_phase (r_s1_sec),
        .o_counts          (new_phase)
    );

    dpsc_duty u_duty_pri (
        .i_period (r_primary_period),
        .i_duty   (r_s1_duty_pri),
        .o_count  (new_duty_pri)
    );

    dpsc_duty u_duty_sec (
        .i_period (r_secondary_period),
        .i_duty   (r_s1_duty_sec),
        .o_count  (new_duty_sec)
    );

    // The active set after the item in the input register.
    always_comb begin
        if (r_s1_cmd == CMD_UPDATE) begin
            n_active_phase    = r_shadow_phase;
            n_active_duty_pri = r_shadow_duty_pri;
            n_active_duty_sec = r_shadow_duty_sec;
        end else begin
            n_active_phase    = r_active_phase;
            n_active_duty_pri = r_active_duty_pri;
            n_active_duty_sec = r_active_duty_sec;
        end
    end

    // Control state, periods and compare sets.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_master_period    <= PERIOD_RESET;
            r_primary_period   <= PERIOD_RESET;
            r_secondary_period <= PERIOD_RESET;
            r_s1_valid         <= 1'b0;
            r_out_valid        <= 1'b0;
            r_shadow_phase     <= '0;
            r_shadow_duty_pri  <= '0;
            r_shadow_duty_sec  <= '0;
            r_active_phase     <= '0;
            r_active_duty_pri  <= '0;
            r_active_duty_sec  <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    REG_MASTER_PERIOD:    r_master_period    <= i_cfg_data;
                    REG_PRIMARY_PERIOD:   r_primary_period   <= i_cfg_data;
                    REG_SECONDARY_PERIOD: r_secondary_period <= i_cfg_data;
                    default: ;
                endcase
            end
            r_s1_valid <= in_accept || (r_s1_valid && !s1_adv);
            if (out_free) begin
                r_out_valid <= r_s1_valid;
            end
            if (s1_adv) begin
                unique case (r_s1_cmd)
                    CMD_SET_PHASES: r_shadow_phase <= new_phase;
                    CMD_SET_DUTIES: begin
                        r_shadow_duty_pri <= new_duty_pri;
                        r_shadow_duty_sec <= new_duty_sec;
                    end
                    default: ;
                endcase
                r_active_phase    <= n_active_phase;
                r_active_duty_pri <= n_active_duty_pri;
                r_active_duty_sec <= n_active_duty_sec;
            end
        end
    end

    // Input register payload.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_cmd      <= i_command;
            r_s1_main     <= i_main_phase;
            r_s1_pri      <= i_primary_phase;
            r_s1_sec      <= i_secondary_phase;
            r_s1_duty_pri <= i_primary_duty;
            r_s1_duty_sec <= i_secondary_duty;
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_phase    <= n_active_phase;
            r_out_duty_pri <= n_active_duty_pri;
            r_out_duty_sec <= n_active_duty_sec;
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_active_compare_a   = r_out_phase.cmp_a;
    assign o_active_compare_pri = r_out_phase.cmp_pri;
    assign o_active_compare_b   = r_out_phase.cmp_b;
    assign o_active_compare_sec = r_out_phase.cmp_sec;
    assign o_active_duty_pri    = r_out_duty_pri;
    assign o_active_duty_sec    = r_out_duty_sec;

endmodule

// ===== hdl/dpsc_phase.sv =====
// Phase setpoints to the four master compare counts.
// Depends on dpsc_pkg.
module dpsc_phase
    import dpsc_pkg::*;
(
    input  logic [15:0]        i_master_period,
    input  logic signed [15:0] i_main_phase,
    input  logic signed [15:0] i_primary_phase,
    input  logic signed [15:0] i_secondary_phase,
    output t_phase_counts      o_counts
);

    logic [14:0]        half;
    logic signed [15:0] m_c;
    logic signed [15:0] p_c;
    logic signed [15:0] s_c;
    logic [16:0]        a_fac;
    logic [16:0]        b_fac;
    logic [31:0]        prod_a;
    logic [31:0]        prod_b;
    logic [15:0]        cnt_a;
    logic [15:0]        cnt_b;
    logic signed [30:0] prod_p;
    logic signed [30:0] prod_s;
    logic signed [32:0] sum_p;
    logic signed [32:0] sum_s;

    assign half = i_master_period[15:1];

    // Clamp the phases to their symmetric limits.
    always_comb begin
        if (i_main_phase >= MAIN_LIMIT) begin
            m_c = MAIN_LIMIT;
        end else if (i_main_phase <= -MAIN_LIMIT) begin
            m_c = -MAIN_LIMIT;
        end else begin
            m_c = i_main_phase;
        end
        if (i_primary_phase >= BRIDGE_LIMIT) begin
            p_c = BRIDGE_LIMIT;
        end else if (i_primary_phase <= -BRIDGE_LIMIT) begin
            p_c = -BRIDGE_LIMIT;
        end else begin
            p_c = i_primary_phase;
        end
        if (i_secondary_phase >= BRIDGE_LIMIT) begin
            s_c = BRIDGE_LIMIT;
        end else if (i_secondary_phase <= -BRIDGE_LIMIT) begin
            s_c = -BRIDGE_LIMIT;
        end else begin
            s_c = i_secondary_phase;
        end
    end

    // Leg counts: half * (1 +- m/2), truncated. The factors stay positive.
    assign a_fac  = 17'h10000 + {m_c[15], m_c};
    assign b_fac  = 17'h10000 - {m_c[15], m_c};
    assign prod_a = 32'(half) * 32'(a_fac);
    assign prod_b = 32'(half) * 32'(b_fac);
    assign cnt_a  = prod_a[31:16];
    assign cnt_b  = prod_b[31:16];

    // Bridge counts: leg count plus half * phase, floored back to counts.
    // With a very short period the floored sum can go below zero.
    assign prod_p = $signed({1'b0, half}) * p_c;
    assign prod_s = $signed({1'b0, half}) * s_c;
    assign sum_p  = $signed({2'b00, cnt_a, 15'd0}) + 33'(prod_p);
    assign sum_s  = $signed({2'b00, cnt_b, 15'd0}) + 33'(prod_s);

    // Saturate every count to the master period.
    always_comb begin
        o_counts.cmp_a   = sat_count($signed({3'b000, cnt_a}), i_master_period);
        o_counts.cmp_b   = sat_count($signed({3'b000, cnt_b}), i_master_period);
        o_counts.cmp_pri = sat_count(19'($signed(sum_p[32:15])), i_master_period);
        o_counts.cmp_sec = sat_count(19'($signed(sum_s[32:15])), i_master_period);
    end

endmodule

// ===== hdl/dpsc_duty.sv =====
// Duty fraction to a timer compare count for one side.
// Depends on dpsc_pkg.
module dpsc_duty
    import dpsc_pkg::*;
(
    input  logic [15:0] i_period,
    input  logic [16:0] i_duty,
    output logic [15:0] o_count
);

    logic [16:0] duty_c;
    logic [32:0] prod;

    // Clamp to one, scale by the period, truncate and saturate.
    assign duty_c  = (i_duty > DUTY_ONE) ? DUTY_ONE : i_duty;
    assign prod    = 33'(i_period) * 33'(duty_c);
    assign o_count = sat_count($signed({2'b00, prod[32:16]}), i_period);

endmodule

// ===== verif/tb_dab_phase_shift_setpoint_to_compare.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for dab_phase_shift_setpoint_to_compare: directed and random
// setpoint items are predicted in the testbench and every result item is checked.
// Depends on dpsc_pkg and the RTL of the block.
module tb_dab_phase_shift_setpoint_to_compare;
    import dpsc_pkg::*;

    // Codes that the package leaves unnamed.
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam logic [1:0] REG_UNUSED = 2'd3;

    localparam int IDLE_PCT       = 6;
    localparam int CALM_FIRST     = 600;
    localparam int CALM_LAST      = 800;
    localparam int HOLD_AT        = 400;
    localparam int HOLD_LEN       = 60;
    localparam int SETTLE_CYCLES  = 4;
    localparam int TAIL_CYCLES    = 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SEGMENTS       = 5;
    localparam int SEGMENT_ITEMS  = 230;

    // One setpoint item as it goes into the block.
    typedef struct packed {
        logic [1:0]         command;
        logic signed [15:0] main_phase;
        logic signed [15:0] primary_phase;
        logic signed [15:0] secondary_phase;
        logic [16:0]        primary_duty;
        logic [16:0]        secondary_duty;
    } t_setpoint;

    // One full set of compare counts, shadow or active.
    typedef struct packed {
        logic [15:0] cmp_a;
        logic [15:0] cmp_pri;
        logic [15:0] cmp_b;
        logic [15:0] cmp_sec;
        logic [15:0] duty_pri;
        logic [15:0] duty_sec;
    } t_compare_set;

    typedef enum logic [1:0] {FEED_ITEM, FEED_CFG, FEED_PAUSE} t_feed_kind;

    // An entry of the stimulus list: an item, a period write or a pause.
    typedef struct {
        t_feed_kind  kind;
        t_setpoint   sp;
        logic [1:0]  index;
        logic [15:0] data;
    } t_feed_entry;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_wr_en = 1'b0;
    logic [1:0]         i_cfg_index = '0;
    logic [15:0]        i_cfg_data = '0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic [1:0]         i_command = '0;
    logic signed [15:0] i_main_phase = '0;
    logic signed [15:0] i_primary_phase = '0;
    logic signed [15:0] i_secondary_phase = '0;
    logic [16:0]        i_primary_duty = '0;
    logic [16:0]        i_secondary_duty = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic [15:0]        o_active_compare_a;
    logic [15:0]        o_active_compare_pri;
    logic [15:0]        o_active_compare_b;
    logic [15:0]        o_active_compare_sec;
    logic [15:0]        o_active_duty_pri;
    logic [15:0]        o_active_duty_sec;

    t_feed_entry  feed_q[$];
    t_compare_set expected_q[$];
    t_setpoint    cur_sp = '0;
    int           items_taken = 0;
    int           results_seen = 0;
    int           quiet_cycles = 0;
    int           hold_left = 0;
    bit           hold_done = 1'b0;
    int           error_count = 0;
    int           stuck_cycles = 0;

    // Predicted state of the block.
    logic [15:0]  master_period = PERIOD_RESET;
    logic [15:0]  primary_period = PERIOD_RESET;
    logic [15:0]  secondary_period = PERIOD_RESET;
    t_compare_set shadow_counts = '0;
    t_compare_set active_counts = '0;

    dab_phase_shift_setpoint_to_compare dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_wr_en          (i_cfg_wr_en),
        .i_cfg_index          (i_cfg_index),
        .i_cfg_data           (i_cfg_data),
        .i_in_valid           (i_in_valid),
        .o_in_stall           (o_in_stall),
        .i_command            (i_command),
        .i_main_phase         (i_main_phase),
        .i_primary_phase      (i_primary_phase),
        .i_secondary_phase    (i_secondary_phase),
        .i_primary_duty       (i_primary_duty),
        .i_secondary_duty     (i_secondary_duty),
        .o_out_valid          (o_out_valid),
        .i_out_stall          (i_out_stall),
        .o_active_compare_a   (o_active_compare_a),
        .o_active_compare_pri (o_active_compare_pri),
        .o_active_compare_b   (o_active_compare_b),
        .o_active_compare_sec (o_active_compare_sec),
        .o_active_duty_pri    (o_active_duty_pri),
        .o_active_duty_sec    (o_active_duty_sec)
    );

    // Clock with an 8 ns period.
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // A count is limited to 1..period-1, where period-1 wraps at 16 bits and wins.
    function automatic logic [15:0] saturate_count(longint value, logic [15:0] period);
        logic [15:0] top;
        longint      top_wide;
        top = period - 16'd1;
        top_wide = top;
        if (value >= top_wide) return top;
        if (value <= 1) return 16'd1;
        return value[15:0];
    endfunction

    function automatic longint clamp_phase(logic signed [15:0] phase, longint limit);
        longint v;
        v = phase;
        if (v >= limit) return limit;
        if (v <= -limit) return -limit;
        return v;
    endfunction

    // Applies one item to the predicted state and returns the active set after it.
    function automatic t_compare_set apply_setpoint(t_setpoint sp);
        longint half, m, p, s, cnt_a, cnt_b, cnt_pri, cnt_sec, per, dp, ds;
        case (sp.command)
            CMD_SET_PHASES: begin
                half = master_period >> 1;
                m = clamp_phase(sp.main_phase, longint'(MAIN_LIMIT));
                p = clamp_phase(sp.primary_phase, longint'(BRIDGE_LIMIT));
                s = clamp_phase(sp.secondary_phase, longint'(BRIDGE_LIMIT));
                cnt_a = (half * (65536 + m)) >>> 16;
                cnt_b = (half * (65536 - m)) >>> 16;
                // The bridge offsets floor toward minus infinity.
                cnt_pri = (cnt_a * 32768 + half * p) >>> 15;
                cnt_sec = (cnt_b * 32768 + half * s) >>> 15;
                shadow_counts.cmp_a = saturate_count(cnt_a, master_period);
                shadow_counts.cmp_pri = saturate_count(cnt_pri, master_period);
                shadow_counts.cmp_b = saturate_count(cnt_b, master_period);
                shadow_counts.cmp_sec = saturate_count(cnt_sec, master_period);
            end
            CMD_SET_DUTIES: begin
                dp = (sp.primary_duty > DUTY_ONE) ? DUTY_ONE : sp.primary_duty;
                ds = (sp.secondary_duty > DUTY_ONE) ? DUTY_ONE : sp.secondary_duty;
                per = primary_period;
                shadow_counts.duty_pri = saturate_count((per * dp) >>> 16, primary_period);
                per = secondary_period;
                shadow_counts.duty_sec = saturate_count((per * ds) >>> 16, secondary_period);
            end
            CMD_UPDATE: begin
                active_counts = shadow_counts;
            end
            default: begin
            end
        endcase
        return active_counts;
    endfunction

    // Writes to an index without a register are dropped.
    function automatic void store_period(logic [1:0] index, logic [15:0] value);
        case (index)
            REG_MASTER_PERIOD:    master_period = value;
            REG_PRIMARY_PERIOD:   primary_period = value;
            REG_SECONDARY_PERIOD: secondary_period = value;
            default: begin
            end
        endcase
    endfunction

    function automatic void push_setpoint(logic [1:0] command, int main_ph, int pri_ph,
                                          int sec_ph, int duty_p, int duty_s);
        t_feed_entry e;
        e.kind = FEED_ITEM;
        e.sp.command = command;
        e.sp.main_phase = main_ph[15:0];
        e.sp.primary_phase = pri_ph[15:0];
        e.sp.secondary_phase = sec_ph[15:0];
        e.sp.primary_duty = duty_p[16:0];
        e.sp.secondary_duty = duty_s[16:0];
        e.index = '0;
        e.data = '0;
        feed_q.push_back(e);
    endfunction

    function automatic void push_period_write(logic [1:0] index, int value);
        t_feed_entry e;
        e.kind = FEED_CFG;
        e.sp = '0;
        e.index = index;
        e.data = value[15:0];
        feed_q.push_back(e);
    endfunction

    function automatic void push_pause();
        t_feed_entry e;
        e.kind = FEED_PAUSE;
        e.sp = '0;
        e.index = '0;
        e.data = '0;
        feed_q.push_back(e);
    endfunction

    // Phases come from the full range, inside the clamp or right at its edges.
    function automatic int rand_phase(int limit);
        case ($urandom_range(3))
            0: return int'($urandom_range(65535)) - 32768;
            1: return int'($urandom_range(2 * limit)) - limit;
            2: return limit - 2 + int'($urandom_range(4));
            default: return -limit - 2 + int'($urandom_range(4));
        endcase
    endfunction

    // Duties cover the legal range, values above one, and both ends.
    function automatic int rand_duty();
        case ($urandom_range(3))
            0: return int'($urandom_range(65536));
            1: return int'($urandom_range(131071));
            2: return int'($urandom_range(3));
            default: return 65534 + int'($urandom_range(4));
        endcase
    endfunction

    function automatic int rand_period(int mode);
        case (mode)
            0: return 65535;
            1: return int'($urandom_range(40, 2));
            default: return int'($urandom_range(65535, 2));
        endcase
    endfunction

    // Mostly set commands mixed with updates, with a few unused commands.
    function automatic void push_random_setpoint();
        int         r;
        logic [1:0] cmd;
        r = $urandom_range(99);
        if (r < 38) cmd = CMD_SET_PHASES;
        else if (r < 72) cmd = CMD_SET_DUTIES;
        else if (r < 96) cmd = CMD_UPDATE;
        else cmd = CMD_UNUSED;
        push_setpoint(cmd, rand_phase(MAIN_LIMIT), rand_phase(BRIDGE_LIMIT),
                      rand_phase(BRIDGE_LIMIT), rand_duty(), rand_duty());
    endfunction

    function automatic void check_count(string label, logic [15:0] want, logic [15:0] got);
        if (want !== got) begin
            error_count++;
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, label, want, got);
        end
    endfunction

    // Item driver: offers queued items, performs period writes once idle, and
    // records the expected result of every accepted item.
    always @(posedge i_clk) begin : drive_items
        t_feed_entry head;
        logic        take_in;
        logic        nxt_valid;
        logic        nxt_wr;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            i_cfg_wr_en <= 1'b0;
        end else begin
            take_in = i_in_valid && !o_in_stall;
            nxt_valid = i_in_valid && !take_in;
            nxt_wr = 1'b0;
            if (take_in) begin
                expected_q.push_back(apply_setpoint(cur_sp));
                items_taken++;
            end
            if (expected_q.size() == 0 && !i_in_valid && !i_cfg_wr_en)
                quiet_cycles++;
            else
                quiet_cycles = 0;
            if (!nxt_valid && feed_q.size() > 0) begin
                head = feed_q[0];
                case (head.kind)
                    FEED_ITEM: begin
                        if ((items_taken >= CALM_FIRST && items_taken < CALM_LAST) ||
                            $urandom_range(99) >= IDLE_PCT) begin
                            void'(feed_q.pop_front());
                            cur_sp = head.sp;
                            nxt_valid = 1'b1;
                            i_command <= head.sp.command;
                            i_main_phase <= head.sp.main_phase;
                            i_primary_phase <= head.sp.primary_phase;
                            i_secondary_phase <= head.sp.secondary_phase;
                            i_primary_duty <= head.sp.primary_duty;
                            i_secondary_duty <= head.sp.secondary_duty;
                        end
                    end
                    FEED_CFG: begin
                        // Registers change only with the pipeline empty.
                        if (quiet_cycles >= SETTLE_CYCLES) begin
                            void'(feed_q.pop_front());
                            nxt_wr = 1'b1;
                            i_cfg_index <= head.index;
                            i_cfg_data <= head.data;
                            store_period(head.index, head.data);
                        end
                    end
                    default: begin
                        if (quiet_cycles >= SETTLE_CYCLES) void'(feed_q.pop_front());
                    end
                endcase
            end
            i_in_valid <= nxt_valid;
            i_cfg_wr_en <= nxt_wr;
        end
    end

    // Result monitor: compares each result item with the oldest expectation and
    // drives the output stall, including one long hold-off.
    always @(posedge i_clk) begin : watch_results
        t_compare_set got;
        t_compare_set want;
        logic         nxt_stall;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            got = '{cmp_a: o_active_compare_a, cmp_pri: o_active_compare_pri,
                    cmp_b: o_active_compare_b, cmp_sec: o_active_compare_sec,
                    duty_pri: o_active_duty_pri, duty_sec: o_active_duty_sec};
            if (expected_q.size() == 0) begin
                error_count++;
                $display("%0t: result item with nothing expected, actual %h", $time, got);
            end else begin
                want = expected_q.pop_front();
                check_count("active_compare_a", want.cmp_a, got.cmp_a);
                check_count("active_compare_pri", want.cmp_pri, got.cmp_pri);
                check_count("active_compare_b", want.cmp_b, got.cmp_b);
                check_count("active_compare_sec", want.cmp_sec, got.cmp_sec);
                check_count("active_duty_pri", want.duty_pri, got.duty_pri);
                check_count("active_duty_sec", want.duty_sec, got.duty_sec);
            end
        end
        if (hold_left > 0) begin
            hold_left--;
            nxt_stall = 1'b1;
        end else if (results_seen == HOLD_AT && !hold_done) begin
            // Hold off long enough for the block to fill and stall its input.
            hold_done = 1'b1;
            hold_left = HOLD_LEN - 1;
            nxt_stall = 1'b1;
        end else if (results_seen >= CALM_FIRST && results_seen < CALM_LAST) begin
            nxt_stall = 1'b0;
        end else begin
            nxt_stall = ($urandom_range(99) < IDLE_PCT);
        end
        i_out_stall <= nxt_stall;
    end

    // Watchdog on cycles in which no item moves on either channel.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
            $display("** dab_phase_shift_setpoint_to_compare: FAILED **");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    // Stimulus list, reset and end of run.
    initial begin : run_test
        int seg;
        int n;
        int mode;

        // Reset state, clamping at both ends, unused fields and the unused command.
        push_setpoint(CMD_UPDATE, 0, 0, 0, 0, 0);
        push_setpoint(CMD_SET_PHASES, 32767, 32767, -32768, 0, 0);
        push_setpoint(CMD_UPDATE, 0, 0, 0, 0, 0);
        push_setpoint(CMD_SET_PHASES, -32768, -32768, 32767, 131071, 131071);
        push_setpoint(CMD_SET_DUTIES, 32767, -32768, 32767, 65536, 0);
        push_setpoint(CMD_UPDATE, -32768, 32767, -32768, 131071, 131071);
        push_setpoint(CMD_SET_PHASES, 8192, 13107, -13107, 0, 0);
        push_setpoint(CMD_SET_DUTIES, 0, 0, 0, 131071, 65535);
        push_setpoint(CMD_UNUSED, 0, 0, 0, 65536, 65536);
        push_setpoint(CMD_UPDATE, 0, 0, 0, 0, 0);

        // A period of zero wraps the upper bound to 65535.
        push_period_write(REG_MASTER_PERIOD, 0);
        push_period_write(REG_PRIMARY_PERIOD, 1);
        push_period_write(REG_SECONDARY_PERIOD, 0);
        push_setpoint(CMD_SET_PHASES, -8192, 0, 13107, 0, 0);
        push_setpoint(CMD_SET_DUTIES, 0, 0, 0, 65536, 1);
        push_setpoint(CMD_UPDATE, 0, 0, 0, 0, 0);

        // A period of one forces the counts on the master and secondary periods to zero.
        push_period_write(REG_MASTER_PERIOD, 1);
        push_period_write(REG_PRIMARY_PERIOD, 0);
        push_period_write(REG_SECONDARY_PERIOD, 1);
        push_setpoint(CMD_SET_PHASES, 4000, -13107, 13107, 0, 0);
        push_setpoint(CMD_SET_DUTIES, 0, 0, 0, 1, 65536);
        push_setpoint(CMD_UPDATE, 0, 0, 0, 0, 0);

        // Smallest legal master and primary periods, and a write to an index without a register.
        push_period_write(REG_MASTER_PERIOD, 2);
        push_period_write(REG_PRIMARY_PERIOD, 2);
        push_period_write(REG_SECONDARY_PERIOD, 65535);
        push_period_write(REG_UNUSED, 16'h1234);
        push_setpoint(CMD_SET_PHASES, 32767, -32768, 32767, 0, 0);
        push_setpoint(CMD_SET_DUTIES, 0, 0, 0, 65536, 65535);
        push_setpoint(CMD_UPDATE, 0, 0, 0, 0, 0);

        // Random segments, each with its own period setting.
        for (seg = 0; seg < SEGMENTS; seg++) begin
            mode = (seg == 0) ? 0 : ((seg == 2) ? 1 : 2);
            push_period_write(REG_MASTER_PERIOD, rand_period(mode));
            push_period_write(REG_PRIMARY_PERIOD, rand_period(mode));
            push_period_write(REG_SECONDARY_PERIOD, rand_period(mode));
            for (n = 0; n < SEGMENT_ITEMS; n++) begin
                if (seg == 3 && n == SEGMENT_ITEMS / 2) push_pause();
                push_random_setpoint();
            end
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (feed_q.size() > 0 || i_in_valid || expected_q.size() > 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (error_count == 0 && expected_q.size() == 0) begin
            $display("** dab_phase_shift_setpoint_to_compare: PASSED **");
        end else begin
            $display("** dab_phase_shift_setpoint_to_compare: FAILED **");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hdl/dpsc_pkg.sv
hdl/dpsc_phase.sv
hdl/dpsc_duty.sv
hdl/dab_phase_shift_setpoint_to_compare.sv
verif/tb_dab_phase_shift_setpoint_to_compare.sv
